[hw/rtl/bce_pkg.sv]
// shared constants, register codes and lane control type of the bit channel extractor
package bce_pkg;

   localparam int MAX_CHANNELS     = 4;
   localparam int MAX_CHANNEL_BITS = 8;
   localparam int MAX_WORD_BITS    = 64;

   localparam int NUM_OUT_CHANNELS = 4;
   localparam int WORD_W           = 64;
   localparam int SLOT_BITS        = 6;
   localparam int NUM_SLOTS        = 8;
   localparam int MAP_W            = SLOT_BITS * NUM_SLOTS;
   localparam int BYTE_W           = 8;
   localparam int RES_W            = 7;
   localparam int ACC_W            = 15;

   localparam int WBITS_W  = 7;
   localparam int CBITS_W  = 4;
   localparam int CCOUNT_W = 3;
   localparam int FILL_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = MAP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WORD_BITS     = 3'd0,
      REG_CHANNEL_BITS  = 3'd1,
      REG_CHANNEL_COUNT = 3'd2,
      REG_CHAN0_MAP     = 3'd3,
      REG_CHAN1_MAP     = 3'd4,
      REG_CHAN2_MAP     = 3'd5,
      REG_CHAN3_MAP     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                active;
      logic [WBITS_W-1:0]  limit;
      logic [CBITS_W-1:0]  nbits;
      logic [FILL_W-1:0]   fill;
   } lane_ctrl_type;

endpackage

[hw/rtl/bit_channel_extractor.sv]
// bit channel extractor: input stage and result registers; a held result stalls input
// throughput one request beat per cycle otherwise; a result beat follows every word that
// completes eight bits per channel, so one result per 8/channel_bits words on average
// the pace is set by the single gather-and-merge pass between input and result registers
// synchronous active-high reset: registers to defaults, residuals and fill count cleared
module bit_channel_extractor
   import bce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [WORD_W-1:0]     req_data_word,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_chan0_byte,
   output logic [BYTE_W-1:0]     rsp_chan1_byte,
   output logic [BYTE_W-1:0]     rsp_chan2_byte,
   output logic [BYTE_W-1:0]     rsp_chan3_byte,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [WBITS_W-1:0]  word_bits_ff;
   logic [CBITS_W-1:0]  channel_bits_ff;
   logic [CCOUNT_W-1:0] channel_count_ff;
   logic [MAP_W-1:0]    chan_map_ff [NUM_OUT_CHANNELS];

   // input stage
   logic                in_valid_ff;
   logic [WORD_W-1:0]   in_word_ff;

   // per-channel carry-over and shared fill count
   logic [RES_W-1:0]    residual_ff [NUM_OUT_CHANNELS];
   logic [RES_W-1:0]    residual_in [NUM_OUT_CHANNELS];
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;

   // output stage
   logic                out_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff [NUM_OUT_CHANNELS];

   // working signals
   logic [WBITS_W-1:0]  limit;
   logic [CBITS_W-1:0]  nbits;
   logic [CCOUNT_W-1:0] nchan;
   logic [CBITS_W:0]    total;
   logic                emit;
   logic                advance;
   logic                req_take;
   lane_ctrl_type       lane_ctrl [NUM_OUT_CHANNELS];
   logic [ACC_W-1:0]    acc [NUM_OUT_CHANNELS];

   // saturate the register values to what the datapath supports
   always_comb begin
      limit = (word_bits_ff > WBITS_W'(MAX_WORD_BITS)) ? WBITS_W'(MAX_WORD_BITS) : word_bits_ff;
      nbits = (channel_bits_ff > CBITS_W'(MAX_CHANNEL_BITS)) ?
              CBITS_W'(MAX_CHANNEL_BITS) : channel_bits_ff;
      nchan = channel_count_ff;
      if (nchan > CCOUNT_W'(MAX_CHANNELS))
         nchan = CCOUNT_W'(MAX_CHANNELS);
      if (nchan > CCOUNT_W'(NUM_OUT_CHANNELS))
         nchan = CCOUNT_W'(NUM_OUT_CHANNELS);
   end

   // the word in the input stage moves on unless a finished byte set is held up
   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // eight or more gathered bits means every channel emits a byte
   assign total   = {2'b00, fill_ff} + {1'b0, nbits};
   assign emit    = total[FILL_W];
   assign fill_in = total[FILL_W-1:0];

   for (genvar c = 0; c < NUM_OUT_CHANNELS; c++) begin : g_lane
      assign lane_ctrl[c] = '{active: (CCOUNT_W'(c) < nchan), limit: limit,
                              nbits: nbits, fill: fill_ff};

      bce_lane u_lane (
         .word     (in_word_ff),
         .chan_map (chan_map_ff[c]),
         .ctrl     (lane_ctrl[c]),
         .residual (residual_ff[c]),
         .acc      (acc[c])
      );

      // keep what is left above the emitted byte, or everything if none goes out
      assign residual_in[c] = emit ? acc[c][BYTE_W +: RES_W] : acc[c][RES_W-1:0];
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         word_bits_ff     <= WBITS_W'(64);
         channel_bits_ff  <= CBITS_W'(1);
         channel_count_ff <= CCOUNT_W'(1);
         for (int c = 0; c < NUM_OUT_CHANNELS; c++) begin
            chan_map_ff[c] <= '0;
            residual_ff[c] <= '0;
         end
         fill_ff      <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               REG_WORD_BITS:     word_bits_ff     <= csr_data[WBITS_W-1:0];
               REG_CHANNEL_BITS:  channel_bits_ff  <= csr_data[CBITS_W-1:0];
               REG_CHANNEL_COUNT: channel_count_ff <= csr_data[CCOUNT_W-1:0];
               REG_CHAN0_MAP:     chan_map_ff[0]   <= csr_data[MAP_W-1:0];
               REG_CHAN1_MAP:     chan_map_ff[1]   <= csr_data[MAP_W-1:0];
               REG_CHAN2_MAP:     chan_map_ff[2]   <= csr_data[MAP_W-1:0];
               REG_CHAN3_MAP:     chan_map_ff[3]   <= csr_data[MAP_W-1:0];
               default: ;
            endcase
         end

         if (req_take)
            in_valid_ff <= 1'b1;
         else if (advance)
            in_valid_ff <= 1'b0;

         if (advance) begin
            for (int c = 0; c < NUM_OUT_CHANNELS; c++)
               residual_ff[c] <= residual_in[c];
            fill_ff <= fill_in;
         end

         if (advance && emit)
            out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall)
            out_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take)
         in_word_ff <= req_data_word;
      if (advance && emit) begin
         for (int c = 0; c < NUM_OUT_CHANNELS; c++)
            out_byte_ff[c] <= acc[c][BYTE_W-1:0];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_chan0_byte = out_byte_ff[0];
   assign rsp_chan1_byte = out_byte_ff[1];
   assign rsp_chan2_byte = out_byte_ff[2];
   assign rsp_chan3_byte = out_byte_ff[3];

endmodule

[hw/rtl/bce_lane.sv]
// one output channel: picks the mapped source bits and merges them into the residual
module bce_lane
   import bce_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   input  logic [MAP_W-1:0]  chan_map,
   input  lane_ctrl_type     ctrl,
   input  logic [RES_W-1:0]  residual,
   output logic [ACC_W-1:0]  acc
);

   logic [NUM_SLOTS-1:0] new_bits;
   logic [SLOT_BITS-1:0] idx [NUM_SLOTS];

   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         idx[s] = chan_map[s*SLOT_BITS +: SLOT_BITS];
         // index past the word reads as zero
         new_bits[s] = ctrl.active && (CBITS_W'(s) < ctrl.nbits) &&
                       ({1'b0, idx[s]} < ctrl.limit) && word[idx[s]];
      end
      acc = (ctrl.active ? ACC_W'(residual) : '0) | (ACC_W'(new_bits) << ctrl.fill);
   end

endmodule

[dv/tb.sv]
// self-checking testbench for the bit channel extractor: random words, stalls and register sets
`timescale 1ns / 1ps

module tb;
   import bce_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;   // no register behind this index
   localparam logic [WORD_W-1:0]    ALL_ONES   = {WORD_W{1'b1}};
   localparam logic [WORD_W-1:0]    TOP_BIT    = {1'b1, {(WORD_W-1){1'b0}}};
   localparam int STUCK_LIMIT   = 2000;   // cycles without any beat before giving up
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_WORDS   = 140;

   typedef logic [NUM_OUT_CHANNELS-1:0][BYTE_W-1:0] lane_bytes_type;

   // dut ports, all driven to known values from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [WORD_W-1:0]     req_data_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_chan0_byte;
   logic [BYTE_W-1:0]     rsp_chan1_byte;
   logic [BYTE_W-1:0]     rsp_chan2_byte;
   logic [BYTE_W-1:0]     rsp_chan3_byte;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the register file, reset values
   logic [WBITS_W-1:0]  cfg_word_bits     = 7'd64;
   logic [CBITS_W-1:0]  cfg_channel_bits  = 4'd1;
   logic [CCOUNT_W-1:0] cfg_channel_count = 3'd1;
   logic [MAP_W-1:0]    cfg_map [NUM_OUT_CHANNELS] = '{default: '0};

   // shadow of the lane accumulators
   logic [RES_W-1:0]    lane_residual [NUM_OUT_CHANNELS] = '{default: '0};
   logic [FILL_W-1:0]   lane_fill = '0;

   logic [WORD_W-1:0]   words_to_send [$];
   lane_bytes_type      expected_bytes [$];
   lane_bytes_type      want_bytes, got_bytes;

   bit sender_idle_on   = 1'b0;
   bit receiver_idle_on = 1'b0;
   int send_gap    = 0;
   int stall_left  = 0;
   int stuck_cycles = 0;
   int fault_count  = 0;

   bit_channel_extractor u_top (.*);

   always #5 clock = ~clock;

   // append one word to the pending request beats
   function automatic void add_word(input logic [WORD_W-1:0] w);
      words_to_send = {words_to_send, w};
   endfunction

   // gather the source bits of one accepted word into every active lane and
   // queue the four bytes if the shared fill count crosses a byte boundary
   function automatic void extract_word(input logic [WORD_W-1:0] w);
      int limit, nbits, nchan, total;
      int idx;
      logic bit_val;
      logic [ACC_W-1:0] acc [NUM_OUT_CHANNELS];
      lane_bytes_type out_bytes;
      limit = (int'(cfg_word_bits) > MAX_WORD_BITS) ? MAX_WORD_BITS : int'(cfg_word_bits);
      nbits = (int'(cfg_channel_bits) > MAX_CHANNEL_BITS) ? MAX_CHANNEL_BITS
                                                         : int'(cfg_channel_bits);
      nchan = (int'(cfg_channel_count) > MAX_CHANNELS) ? MAX_CHANNELS
                                                       : int'(cfg_channel_count);
      if (nchan > NUM_OUT_CHANNELS) nchan = NUM_OUT_CHANNELS;
      for (int c = 0; c < NUM_OUT_CHANNELS; c++) begin
         acc[c] = '0;
         // an inactive lane loses whatever it held
         if (c < nchan) begin
            acc[c] = ACC_W'(lane_residual[c]);
            for (int s = 0; s < nbits; s++) begin
               idx = int'(cfg_map[c][SLOT_BITS*s +: SLOT_BITS]);
               // an index past the word reads as zero
               bit_val = (idx < limit) ? w[idx] : 1'b0;
               acc[c] = acc[c] | (ACC_W'(bit_val) << (int'(lane_fill) + s));
            end
         end
      end
      total = int'(lane_fill) + nbits;
      if (total >= BYTE_W) begin
         for (int c = 0; c < NUM_OUT_CHANNELS; c++) begin
            out_bytes[c] = acc[c][BYTE_W-1:0];
            lane_residual[c] = acc[c][ACC_W-1:BYTE_W];
         end
         lane_fill = FILL_W'(total - BYTE_W);
         expected_bytes = {expected_bytes, out_bytes};
      end else begin
         for (int c = 0; c < NUM_OUT_CHANNELS; c++)
            lane_residual[c] = acc[c][RES_W-1:0];
         lane_fill = FILL_W'(total);
      end
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t %s", $time, msg);
   endfunction

   // eight slot indices stepping from a start point, wrapping inside the word
   function automatic logic [MAP_W-1:0] spread_map(input int start, input int stride);
      logic [MAP_W-1:0] m;
      for (int s = 0; s < NUM_SLOTS; s++)
         m[SLOT_BITS*s +: SLOT_BITS] = SLOT_BITS'((start + s * stride) & 63);
      return m;
   endfunction

   // mostly indices that land inside the word, now and then any index at all
   function automatic logic [MAP_W-1:0] random_map(input int reach);
      logic [MAP_W-1:0] m;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (reach == 0 || $urandom_range(0, 3) == 0)
            m[SLOT_BITS*s +: SLOT_BITS] = SLOT_BITS'($urandom_range(0, 63));
         else
            m[SLOT_BITS*s +: SLOT_BITS] = SLOT_BITS'($urandom_range(0, reach - 1));
      end
      return m;
   endfunction

   // one register beat; valid stays up so that back-to-back writes need one drive each
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_WORD_BITS:     cfg_word_bits     = data[WBITS_W-1:0];
         REG_CHANNEL_BITS:  cfg_channel_bits  = data[CBITS_W-1:0];
         REG_CHANNEL_COUNT: cfg_channel_count = data[CCOUNT_W-1:0];
         REG_CHAN0_MAP:     cfg_map[0] = data;
         REG_CHAN1_MAP:     cfg_map[1] = data;
         REG_CHAN2_MAP:     cfg_map[2] = data;
         REG_CHAN3_MAP:     cfg_map[3] = data;
         default: ;
      endcase
   endtask

   // whole register set, junk above the narrow fields, plus a write to the empty index
   task automatic load_config(input int wb, input int cb, input int cc,
                              input logic [MAP_W-1:0] m0, input logic [MAP_W-1:0] m1,
                              input logic [MAP_W-1:0] m2, input logic [MAP_W-1:0] m3);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'({$urandom, $urandom});
      csr_write(REG_WORD_BITS,     {noise[CSR_DATA_W-1:WBITS_W], WBITS_W'(wb)});
      csr_write(REG_CHANNEL_BITS,  {noise[CSR_DATA_W-1:CBITS_W], CBITS_W'(cb)});
      csr_write(REG_CHANNEL_COUNT, {noise[CSR_DATA_W-1:CCOUNT_W], CCOUNT_W'(cc)});
      csr_write(REG_CHAN0_MAP, m0);
      csr_write(REG_CHAN1_MAP, m1);
      csr_write(REG_CHAN2_MAP, m2);
      csr_write(REG_CHAN3_MAP, m3);
      csr_write(REG_UNUSED, ~noise);
      csr_valid <= 1'b0;
   endtask

   // every word sent, every byte set back, then room for words still in the pipe
   task automatic wait_for_idle();
      do @(posedge clock);
      while (words_to_send.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   // request driver: payload only moves once the current beat is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) extract_word(req_data_word);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
               req_valid     <= 1'b1;
               req_data_word <= words_to_send.pop_front();
               if (sender_idle_on && $urandom_range(0, 7) == 0)
                  send_gap <= $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with bursty back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_bytes = {rsp_chan3_byte, rsp_chan2_byte, rsp_chan1_byte, rsp_chan0_byte};
            if (expected_bytes.size() == 0) begin
               log_fault($sformatf("result beat %h with nothing expected", got_bytes));
            end else begin
               want_bytes = expected_bytes.pop_front();
               for (int c = 0; c < NUM_OUT_CHANNELS; c++)
                  if (got_bytes[c] !== want_bytes[c])
                     log_fault($sformatf("channel %0d byte: expected %02h got %02h",
                                         c, want_bytes[c], got_bytes[c]));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // count cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("tb: errors");
      $finish;
   end

   initial begin
      int wb, cb, cc, reach;
      logic [WORD_W-1:0] w;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;

      // reset defaults: channel 0 takes bit 0 of each word, one byte per eight words
      words_to_send = '{64'h0, ALL_ONES, 64'h1, TOP_BIT,
                        {32{2'b01}}, {32{2'b10}}, ALL_ONES, 64'h0};
      wait_for_idle();

      // widest setting: all four lanes, eight bits each, top and bottom indices
      load_config(64, 8, 4, spread_map(0, 1), spread_map(56, 1),
                  spread_map(63, -1), spread_map(7, 9));
      add_word(ALL_ONES);
      add_word(64'h0123_4567_89ab_cdef);
      wait_for_idle();

      // short word: indices from five upwards read as zero
      load_config(5, 8, 4, spread_map(0, 1), spread_map(5, 1),
                  spread_map(60, 1), spread_map(3, 1));
      add_word(ALL_ONES);
      wait_for_idle();

      // zero word size: nothing but zero bits
      load_config(0, 8, 4, spread_map(0, 1), spread_map(8, 1),
                  spread_map(16, 1), spread_map(24, 1));
      add_word(ALL_ONES);
      wait_for_idle();

      // oversized word size, channel bits and channel count all saturate
      load_config(127, 15, 7, spread_map(63, -1), spread_map(0, 9),
                  spread_map(32, 4), spread_map(56, 1));
      add_word(ALL_ONES);
      add_word(TOP_BIT | 64'h1);
      wait_for_idle();

      // no channel bits: nothing gathers, nothing comes out
      load_config(64, 0, 4, spread_map(0, 1), spread_map(8, 1),
                  spread_map(16, 1), spread_map(24, 1));
      add_word(ALL_ONES);
      add_word(ALL_ONES);
      wait_for_idle();

      // no active channel: fill still advances, all-zero bytes come out
      load_config(64, 8, 0, spread_map(0, 1), spread_map(8, 1),
                  spread_map(16, 1), spread_map(24, 1));
      add_word(ALL_ONES);
      wait_for_idle();

      // part-filled lanes survive a register change
      load_config(64, 3, 2, spread_map(1, 5), spread_map(62, -3),
                  spread_map(16, 1), spread_map(24, 1));
      add_word(ALL_ONES);
      add_word(64'hdead_beef_0bad_f00d);
      wait_for_idle();
      load_config(64, 5, 3, spread_map(4, 7), spread_map(40, 2),
                  spread_map(20, 3), spread_map(24, 1));
      add_word(64'hf0f0_0f0f_3c3c_c3c3);
      wait_for_idle();

      // random settings, each phase drained before the next set of writes;
      // the last phases run with no idling at all
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0:       wb = 64;
            1:       wb = $urandom_range(65, 127);
            2:       wb = $urandom_range(0, 8);
            default: wb = $urandom_range(1, 64);
         endcase
         case ($urandom_range(0, 7))
            0:       cb = $urandom_range(9, 15);
            1:       cb = 8;
            2:       cb = 1;
            default: cb = $urandom_range(1, 8);
         endcase
         cc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
         reach = (wb > MAX_WORD_BITS) ? MAX_WORD_BITS : wb;
         load_config(wb, cb, cc, random_map(reach), random_map(reach),
                     random_map(reach), random_map(reach));
         sender_idle_on   = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         receiver_idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            case ($urandom_range(0, 15))
               0:       w = '0;
               1:       w = ALL_ONES;
               default: w = {$urandom, $urandom};
            endcase
            add_word(w);
         end
         wait_for_idle();
      end

      if (fault_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
